/* rtl/gaussian_blur_3x3_rgb_top_assert.svh */
// Assertion macros for the checker file
`ifndef GAUSSIAN_BLUR_3X3_RGB_TOP_ASSERT_SVH
`define GAUSSIAN_BLUR_3X3_RGB_TOP_ASSERT_SVH
// same-cycle implication, disabled in reset
`define GB3_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gb3 check failed");
// next-cycle implication, disabled in reset
`define GB3_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gb3 check failed");
// next-cycle implication, active through reset
`define GB3_ASSERT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("gb3 check failed");
`endif

/* rtl/gb3_pkg.sv */
// ----------------------------------------------------------------------------
// gb3_pkg
// Shared types and constants of the 3x3 RGB blur.
// ----------------------------------------------------------------------------
package gb3_pkg;
    localparam int MaxWidth  = 1024;
    localparam int MaxHeight = 1024;
    localparam int CoordW    = 10;
    localparam int CfgW      = 11;
    localparam int ChanW     = 8;
    localparam int PixW      = 3 * ChanW;
    localparam int AddrW     = $clog2(MaxWidth);
    localparam int QDepth    = 4;
    localparam int QPtrW     = $clog2(QDepth);

    localparam logic [0:0] RegWidth  = 1'b0;
    localparam logic [0:0] RegHeight = 1'b1;

    localparam logic [CfgW-1:0] WidthReset  = CfgW'(640);
    localparam logic [CfgW-1:0] HeightReset = CfgW'(480);

    typedef logic [PixW-1:0] t_pix;

    // window entry c*3+s: column c (0 left), row s (0 oldest)
    typedef struct packed {
        logic [8:0][PixW-1:0] win;
        logic [CoordW-1:0]    col;
        logic [CoordW-1:0]    row;
        logic [3:0]           emit;
        logic                 col_ge1;
        logic                 col_ge2;
        logic                 row_ge1;
        logic                 row_ge2;
    } t_job;
endpackage

/* rtl/gb3_pix_if.sv */
// ----------------------------------------------------------------------------
// gb3_pix_if
// Input pixel channel.
// ----------------------------------------------------------------------------
interface gb3_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    modport source (output valid, in_red, in_green, in_blue, input ready);
    modport sink (input valid, in_red, in_green, in_blue, output ready);
endinterface

/* rtl/gb3_res_if.sv */
// ----------------------------------------------------------------------------
// gb3_res_if
// Output result channel.
// ----------------------------------------------------------------------------
interface gb3_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [9:0] out_col;
    logic [9:0] out_row;
    logic       last_of_run;
    logic       frame_done;
    modport source (output valid, out_red, out_green, out_blue, out_col, out_row,
                    last_of_run, frame_done, input ready);
    modport sink (input valid, out_red, out_green, out_blue, out_col, out_row,
                  last_of_run, frame_done, output ready);
endinterface

/* rtl/gb3_front.sv */
// ----------------------------------------------------------------------------
// gb3_front
// Accepts pixels, keeps the line stores and window, and classifies the
// results each pixel causes into a job for the back end.
// ----------------------------------------------------------------------------
module gb3_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [gb3_pkg::CfgW-1:0]   i_width,
    input  logic [gb3_pkg::CfgW-1:0]   i_height,
    gb3_pix_if.sink                    s_pix,
    output logic                       o_job_valid,
    output gb3_pkg::t_job              o_job,
    input  logic                       i_job_ready
);
    import gb3_pkg::*;

    t_pix r_old_mem [MaxWidth];
    t_pix r_new_mem [MaxWidth];

    logic [CoordW-1:0] r_col, r_row;
    logic [CfgW-1:0]   w_eff, h_eff;
    logic              end_row, last_row, accept, s1_move, has_emit;

    logic              r_s1_valid, r_s1_end, r_s1_last, r_s1_fwd;
    logic [CoordW-1:0] r_s1_col, r_s1_row;
    t_pix              r_s1_px, r_rd_a, r_rd_b, r_fwd_a, r_fwd_b, a_eff, b_eff;
    logic [8:0][PixW-1:0] r_win, n_win;
    logic [3:0]        emit;

    always_comb begin
        w_eff = i_width;
        if (i_width == '0) w_eff = CfgW'(1);
        else if (i_width > CfgW'(MaxWidth)) w_eff = CfgW'(MaxWidth);
        h_eff = i_height;
        if (i_height == '0) h_eff = CfgW'(1);
        else if (i_height > CfgW'(MaxHeight)) h_eff = CfgW'(MaxHeight);
    end

    assign end_row  = ({1'b0, r_col} + CfgW'(1)) >= w_eff;
    assign last_row = ({1'b0, r_row} + CfgW'(1)) >= h_eff;

    assign emit[0]  = (r_s1_row != '0) && (r_s1_col != '0);
    assign emit[1]  = (r_s1_row != '0) && r_s1_end;
    assign emit[2]  = r_s1_last && (r_s1_col != '0);
    assign emit[3]  = r_s1_last && r_s1_end;
    assign has_emit = |emit;

    assign s1_move     = r_s1_valid && (!has_emit || i_job_ready);
    assign s_pix.ready = !r_s1_valid || s1_move;
    assign accept      = s_pix.valid && s_pix.ready;

    // bypass a write to the same column that lands on the read edge
    assign a_eff = r_s1_fwd ? r_fwd_a : r_rd_a;
    assign b_eff = r_s1_fwd ? r_fwd_b : r_rd_b;

    always_comb begin
        for (int i = 0; i < 6; i++) n_win[i] = r_win[i+3];
        n_win[6] = a_eff;
        n_win[7] = b_eff;
        n_win[8] = r_s1_px;
    end

    assign o_job_valid    = r_s1_valid && has_emit;
    assign o_job.win      = n_win;
    assign o_job.col      = r_s1_col;
    assign o_job.row      = r_s1_row;
    assign o_job.emit     = emit;
    assign o_job.col_ge1  = r_s1_col != '0;
    assign o_job.col_ge2  = r_s1_col > CoordW'(1);
    assign o_job.row_ge1  = r_s1_row != '0;
    assign o_job.row_ge2  = r_s1_row > CoordW'(1);

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_a <= r_old_mem[r_col[AddrW-1:0]];
            r_rd_b <= r_new_mem[r_col[AddrW-1:0]];
        end
        if (s1_move) begin
            r_old_mem[r_s1_col[AddrW-1:0]] <= b_eff;
            r_new_mem[r_s1_col[AddrW-1:0]] <= r_s1_px;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_col      <= '0;
            r_row      <= '0;
            r_win      <= '0;
        end else begin
            if (s1_move) begin
                r_win   <= n_win;
                r_fwd_a <= b_eff;
                r_fwd_b <= r_s1_px;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
                r_s1_px    <= {s_pix.in_red, s_pix.in_green, s_pix.in_blue};
                r_s1_col   <= r_col;
                r_s1_row   <= r_row;
                r_s1_end   <= end_row;
                r_s1_last  <= last_row;
                r_s1_fwd   <= s1_move && (r_s1_col == r_col);
                if (end_row) begin
                    r_col <= '0;
                    r_row <= last_row ? '0 : r_row + CoordW'(1);
                end else begin
                    r_col <= r_col + CoordW'(1);
                end
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
        end
    end
endmodule

/* rtl/gb3_queue.sv */
// ----------------------------------------------------------------------------
// gb3_queue
// Short job queue between front and back end.
// ----------------------------------------------------------------------------
module gb3_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  gb3_pkg::t_job  i_job,
    output logic           o_ready,
    input  logic           i_pop,
    output logic           o_valid,
    output gb3_pkg::t_job  o_job
);
    import gb3_pkg::*;

    t_job             r_mem [QDepth];
    logic [QPtrW-1:0] r_wptr, r_rptr;
    logic [QPtrW:0]   r_count;
    logic             do_push, do_pop;

    assign o_ready = r_count != (QPtrW+1)'(QDepth);
    assign o_valid = r_count != '0;
    assign o_job   = r_mem[r_rptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wptr] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) r_wptr <= r_wptr + QPtrW'(1);
            if (do_pop)  r_rptr <= r_rptr + QPtrW'(1);
            if (do_push && !do_pop) r_count <= r_count + (QPtrW+1)'(1);
            else if (!do_push && do_pop) r_count <= r_count - (QPtrW+1)'(1);
        end
    end
endmodule

/* rtl/gb3_back.sv */
// ----------------------------------------------------------------------------
// gb3_back
// Walks the results of the head job, one per cycle unless the output stalls,
// computes the weighted sums and holds each result in the output register.
// ----------------------------------------------------------------------------
module gb3_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_valid,
    input  gb3_pkg::t_job  i_job,
    output logic           o_pop,
    gb3_res_if.source      m_res
);
    import gb3_pkg::*;

    logic [3:0]        r_done, pend, sel;
    logic [1:0]        k;
    logic              last_sel, fire, can_load, r_ov;
    logic [1:0]        lc, cc, ts, ms;
    logic [CoordW-1:0] ocol, orow;
    logic [7:0]        res [3];

    assign pend = i_job.emit & ~r_done;

    always_comb begin
        sel = 4'b0000;
        k   = 2'd0;
        for (int i = 3; i >= 0; i--) begin
            if (pend[i]) begin
                sel = 4'b0001 << i;
                k   = 2'(i);
            end
        end
    end

    assign last_sel = (pend & ~sel) == 4'b0000;
    assign can_load = !r_ov || m_res.ready;
    assign fire     = i_job_valid && can_load;
    assign o_pop    = fire && last_sel;

    always_comb begin
        if (k[0]) begin
            lc   = i_job.col_ge1 ? 2'd1 : 2'd2;
            cc   = 2'd2;
            ocol = i_job.col;
        end else begin
            lc   = i_job.col_ge2 ? 2'd0 : 2'd1;
            cc   = 2'd1;
            ocol = i_job.col - CoordW'(1);
        end
        if (k[1]) begin
            ts   = i_job.row_ge1 ? 2'd1 : 2'd2;
            ms   = 2'd2;
            orow = i_job.row;
        end else begin
            ts   = i_job.row_ge2 ? 2'd0 : 2'd1;
            ms   = 2'd1;
            orow = i_job.row - CoordW'(1);
        end
    end

    // vertical 1-2-1 of one column, one channel
    function automatic logic [9:0] vsum(input logic [8:0][PixW-1:0] w, input logic [1:0] c,
                                        input logic [1:0] t, input logic [1:0] m,
                                        input int ch);
        logic [7:0] vt, vm, vb;
        vt = w[4'(c) * 4'd3 + 4'(t)][ch*8 +: 8];
        vm = w[4'(c) * 4'd3 + 4'(m)][ch*8 +: 8];
        vb = w[4'(c) * 4'd3 + 4'd2][ch*8 +: 8];
        return 10'(vt) + {1'b0, vm, 1'b0} + 10'(vb);
    endfunction

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            logic [11:0] s;
            s = 12'(vsum(i_job.win, lc, ts, ms, ch))
              + {1'b0, vsum(i_job.win, cc, ts, ms, ch), 1'b0}
              + 12'(vsum(i_job.win, 2'd2, ts, ms, ch));
            res[ch] = s[11:4];
        end
    end

    assign m_res.valid = r_ov;

    always_ff @(posedge i_clk) begin
        if (fire) begin
            m_res.out_red     <= res[2];
            m_res.out_green   <= res[1];
            m_res.out_blue    <= res[0];
            m_res.out_col     <= ocol;
            m_res.out_row     <= orow;
            m_res.last_of_run <= last_sel;
            m_res.frame_done  <= k == 2'd3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov   <= 1'b0;
            r_done <= 4'b0000;
        end else begin
            if (fire) r_ov <= 1'b1;
            else if (m_res.ready) r_ov <= 1'b0;
            if (fire) r_done <= last_sel ? 4'b0000 : (r_done | sel);
        end
    end
endmodule

/* rtl/gaussian_blur_3x3_rgb_top.sv */
// ----------------------------------------------------------------------------
// gaussian_blur_3x3_rgb_top
// 3x3 1-2-1 Gaussian blur of an RGB raster stream with edge replication.
// ----------------------------------------------------------------------------
// Takes one pixel per clock unless the job queue is full. Each pixel causes
// zero to four output beats (right edge and bottom row flushes), which the
// back end sends at one beat per clock from a four-job queue unless the
// output stalls, so ordinary rows run at one pixel per clock and the bottom
// row at up to four beats per pixel, bounded by the single output register.
// Path to the first beat: line store read and classify, job queue, output
// register. Write frame size only while the block is idle.
module gaussian_blur_3x3_rgb_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [0:0]                i_cfg_idx,
    input  logic [gb3_pkg::CfgW-1:0]  i_cfg_data,
    gb3_pix_if.sink                   s_pix,
    gb3_res_if.source                 m_res
);
    import gb3_pkg::*;

    logic [CfgW-1:0] r_width, r_height;
    logic            f_valid, q_ready, q_valid, pop;
    t_job            f_job, q_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WidthReset;
            r_height <= HeightReset;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                RegWidth:  r_width  <= i_cfg_data;
                RegHeight: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    gb3_front u_front (
        .i_clk, .i_rst_n, .i_width(r_width), .i_height(r_height), .s_pix,
        .o_job_valid(f_valid), .o_job(f_job), .i_job_ready(q_ready)
    );

    gb3_queue u_queue (
        .i_clk, .i_rst_n, .i_push(f_valid), .i_job(f_job), .o_ready(q_ready),
        .i_pop(pop), .o_valid(q_valid), .o_job(q_job)
    );

    gb3_back u_back (
        .i_clk, .i_rst_n, .i_job_valid(q_valid), .i_job(q_job), .o_pop(pop), .m_res
    );
endmodule

/* rtl/gb3_checker.sv */
// ----------------------------------------------------------------------------
// gb3_checker
// Port-level checks on the result channel.
// ----------------------------------------------------------------------------
`include "gaussian_blur_3x3_rgb_top_assert.svh"
module gb3_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic        i_last,
    input logic        i_done,
    input logic [45:0] i_payload
);
    `GB3_ASSERT_ALWAYS(a_idle_after_reset, i_clk, !i_rst_n, !i_valid)
    `GB3_ASSERT_NOW(a_done_is_last, i_clk, i_rst_n, i_valid && i_done, i_last)
    `GB3_ASSERT_NEXT(a_run_continues, i_clk, i_rst_n, i_valid && i_ready && !i_last, i_valid)
    `GB3_ASSERT_NEXT(a_hold_stalled, i_clk, i_rst_n, i_valid && !i_ready,
                     i_valid && $stable(i_payload))
endmodule

bind gaussian_blur_3x3_rgb_top gb3_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(m_res.valid), .i_ready(m_res.ready),
    .i_last(m_res.last_of_run), .i_done(m_res.frame_done),
    .i_payload({m_res.out_red, m_res.out_green, m_res.out_blue, m_res.out_col,
                m_res.out_row, m_res.last_of_run, m_res.frame_done})
);
